// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assert that an implication holds on every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- src/cfm_pkg.sv -----
// Types and constants for the capture frequency meter.
package cfm_pkg;

    localparam int RATE_W     = 24;
    localparam int FREQ_W     = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DIV_CNT_W  = $clog2(RATE_W);
    localparam int BCD_CNT_W  = $clog2(FREQ_W);

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd250000;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'hFFFF;

    // Input item kinds
    typedef enum logic {
        ACT_OVERFLOW = 1'b0,
        ACT_EDGE     = 1'b1
    } action_t;

    // Decimal digits, most significant first
    typedef struct packed {
        logic [3:0] tenk;
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

endpackage

// ----- src/cfm_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module cfm_div
    import cfm_pkg::*;
#(
    parameter int DIVISOR_W = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RATE_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [RATE_W-1:0]    quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RATE_W-1:0]    shift_reg;
    logic [RATE_W-1:0]    shift_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 qbit;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_shift  = {rem_reg, shift_reg[RATE_W-1]};
        rem_diff   = rem_shift - {1'b0, dvs_reg};
        qbit       = (rem_shift >= {1'b0, dvs_reg});
        rem_next   = qbit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        shift_next = {shift_reg[RATE_W-2:0], qbit};
    end

    // Sequence the bit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(RATE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands, shift dividend out and quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ----- src/cfm_bcd.sv -----
// Shift-and-add-3 binary to decimal converter, one bit per cycle.
module cfm_bcd
    import cfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FREQ_W-1:0] value,
    output logic              done,
    output digits_t           digits
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [BCD_CNT_W-1:0] cnt_reg;
    logic [FREQ_W-1:0]    bin_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     adj;
    logic [BCD_W-1:0]     bcd_next;

    // Add three to every digit of five or more, then shift in the next bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
        bcd_next = {adj[BCD_W-2:0], bin_reg[FREQ_W-1]};
    end

    // Sequence the bit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BCD_CNT_W'(FREQ_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the binary and decimal shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[FREQ_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign done   = done_reg;
    assign digits = digits_t'(bcd_reg);

endmodule

// ----- src/capture_frequency_meter.sv -----
// A second capture edge passes through the bit-serial divider, then the decimal converter,
// then waits in S_LOAD until the output register is free; a period that is not positive
// skips the divider and goes straight to the decimal converter.
// Overflow ticks and the opening edge are taken while idle and do not hold the input; the closing edge holds
// the input until its result is in the output register.
// Reset (rst_n low, asynchronous) clears the measurement, the output and sets rate 250000.
module capture_frequency_meter
    import cfm_pkg::*;
#(
    parameter int TIMER_BITS    = 16,
    parameter int OVERFLOW_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RATE_W-1:0] reference_rate,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [15:0]       capture_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       frequency,
    output logic [3:0]        ones_digit,
    output logic [3:0]        tens_digit,
    output logic [3:0]        hundreds_digit,
    output logic [6:0]        thousands_part,
    output logic [2:0]        digit_count,
    output logic              error_flag
);

    localparam int SPAN_W = OVERFLOW_BITS + TIMER_BITS;
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_BCD,
        S_LOAD
    } state_t;

    state_t                   state_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic                     edge_seen_reg;
    logic [TIMER_BITS-1:0]    first_stamp_reg;
    logic [OVERFLOW_BITS-1:0] ovf_count_reg;
    logic                     ovf_sat_reg;
    logic                     err_reg;
    logic [FREQ_W-1:0]        freq_reg;

    logic                     out_valid_reg;
    logic [15:0]              frequency_reg;
    logic [3:0]               ones_reg;
    logic [3:0]               tens_reg;
    logic [3:0]               hundreds_reg;
    logic [6:0]               thousands_reg;
    logic [2:0]               count_reg;
    logic                     error_reg;

    logic                     in_fire;
    logic                     second_edge;
    logic [TIMER_BITS-1:0]    stamp;
    logic [SPAN_W:0]          diff;
    logic                     span_bad;
    logic                     div_start;
    logic                     div_done;
    logic [RATE_W-1:0]        quotient;
    logic [FREQ_W-1:0]        quot_sat;
    logic                     bcd_start;
    logic                     bcd_done;
    logic [FREQ_W-1:0]        bcd_value;
    digits_t                  digits;
    logic [6:0]               thousands_next;
    logic [2:0]               count_next;
    logic                     out_free;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Form the span between the opening and closing capture stamps and check it is positive
    assign stamp       = TIMER_BITS'(capture_value);
    assign second_edge = in_fire && (action == ACT_EDGE) && edge_seen_reg;
    assign diff        = {1'b0, ovf_count_reg, stamp} - (SPAN_W + 1)'(first_stamp_reg);
    assign span_bad    = diff[SPAN_W] || (diff == '0);
    assign div_start   = second_edge && !span_bad;

    // Saturate the quotient to the output width
    assign quot_sat  = (quotient[RATE_W-1:FREQ_W] != '0) ? FREQ_MAX : quotient[FREQ_W-1:0];
    assign bcd_start = div_done || (second_edge && span_bad);
    assign bcd_value = div_done ? quot_sat : '0;

    cfm_div #(
        .DIVISOR_W (SPAN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rate_reg),
        .divisor  (diff[SPAN_W-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    cfm_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .value  (bcd_value),
        .done   (bcd_done),
        .digits (digits)
    );

    // Merge the top two decimal digits and count the digit positions in use, the merged thousands part as one
    always_comb
    begin
        thousands_next = ({3'b000, digits.tenk} << 3) + ({3'b000, digits.tenk} << 1)
                       + {3'b000, digits.thou};
        if (digits.tenk != 4'd0 || digits.thou != 4'd0)
            count_next = 3'd4;
        else if (digits.hund != 4'd0)
            count_next = 3'd3;
        else if (digits.tens != 4'd0)
            count_next = 3'd2;
        else
            count_next = 3'd1;
    end

    // Sequence the measurement, hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rate_reg        <= RATE_RESET;
            edge_seen_reg   <= 1'b0;
            first_stamp_reg <= '0;
            ovf_count_reg   <= '0;
            ovf_sat_reg     <= 1'b0;
            err_reg         <= 1'b0;
            freq_reg        <= '0;
            out_valid_reg   <= 1'b0;
            frequency_reg   <= '0;
            ones_reg        <= '0;
            tens_reg        <= '0;
            hundreds_reg    <= '0;
            thousands_reg   <= '0;
            count_reg       <= '0;
            error_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rate_reg <= reference_rate;

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (bcd_start)
                freq_reg <= bcd_value;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (action == ACT_OVERFLOW)
                        begin
                            if (edge_seen_reg)
                            begin
                                if (ovf_count_reg == OVF_MAX)
                                    ovf_sat_reg <= 1'b1;
                                else
                                    ovf_count_reg <= ovf_count_reg + 1'b1;
                            end
                        end
                        else if (!edge_seen_reg)
                        begin
                            first_stamp_reg <= stamp;
                            ovf_count_reg   <= '0;
                            ovf_sat_reg     <= 1'b0;
                            edge_seen_reg   <= 1'b1;
                        end
                        else
                        begin
                            err_reg         <= ovf_sat_reg || span_bad;
                            edge_seen_reg   <= 1'b0;
                            first_stamp_reg <= '0;
                            ovf_count_reg   <= '0;
                            ovf_sat_reg     <= 1'b0;
                            state_reg       <= span_bad ? S_BCD : S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_BCD;
                end
                S_BCD:
                begin
                    if (bcd_done)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        frequency_reg <= freq_reg;
                        ones_reg      <= digits.ones;
                        tens_reg      <= digits.tens;
                        hundreds_reg  <= digits.hund;
                        thousands_reg <= thousands_next;
                        count_reg     <= count_next;
                        error_reg     <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign frequency      = frequency_reg;
    assign ones_digit     = ones_reg;
    assign tens_digit     = tens_reg;
    assign hundreds_digit = hundreds_reg;
    assign thousands_part = thousands_reg;
    assign digit_count    = count_reg;
    assign error_flag     = error_reg;

endmodule

// ----- src/cfm_checker.sv -----
// Port-level checks on the capture frequency meter, bound to the top level.
`include "assert_macros.svh"

module cfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] frequency,
    input logic [3:0]  ones_digit,
    input logic [3:0]  tens_digit,
    input logic [3:0]  hundreds_digit,
    input logic [6:0]  thousands_part,
    input logic [2:0]  digit_count,
    input logic        error_flag
);

    logic [16:0] recombined;

    // Rebuild the binary value from its decimal parts
    assign recombined = 17'(thousands_part) * 17'd1000 + 17'(hundreds_digit) * 17'd100
                      + 17'(tens_digit) * 17'd10 + 17'(ones_digit);

    // Hold a stalled item's valid, frequency and error flag
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(frequency) && $stable(error_flag), "output item changed while stalled")

    // Keep every decimal digit in range
    `ASSERT_IMPLY(a_digit_range, clk, rst_n, out_valid, ones_digit <= 4'd9 && tens_digit <= 4'd9 && hundreds_digit <= 4'd9 && thousands_part <= 7'd65, "decimal digit out of range")

    // Match the decimal parts to the frequency
    `ASSERT_IMPLY(a_digits_match, clk, rst_n, out_valid, recombined == {1'b0, frequency}, "decimal parts disagree with frequency")

    // Match the digit count to the magnitude
    `ASSERT_IMPLY(a_count_match, clk, rst_n, out_valid, (frequency < 16'd10 && digit_count == 3'd1) || (frequency >= 16'd10 && frequency < 16'd100 && digit_count == 3'd2) || (frequency >= 16'd100 && frequency < 16'd1000 && digit_count == 3'd3) || (frequency >= 16'd1000 && digit_count == 3'd4), "digit count disagrees with frequency")

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frequency      (frequency),
    .ones_digit     (ones_digit),
    .tens_digit     (tens_digit),
    .hundreds_digit (hundreds_digit),
    .thousands_part (thousands_part),
    .digit_count    (digit_count),
    .error_flag     (error_flag)
);
